FILE: sv/button_press_classifier_unit_macros.svh
// Assertion macros used by the button press classifier top level.
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define BPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/bpc_pkg.sv
// Types and constants of the button press classifier.
`default_nettype none
package bpc_pkg;

   localparam int NumButtons   = 4;
   localparam int LevelWidth   = 4;
   localparam int ButtonWidth  = 2;
   localparam int TickWidth    = 16;
   localparam int PressWidth   = 9;
   localparam int ThreshWidth  = 8;
   localparam int CsrDataWidth = 16;
   localparam int CsrIndexWidth = 2;
   // only the buttons that have a level bit can be latched
   localparam int ScanButtons  = (NumButtons < LevelWidth) ? NumButtons : LevelWidth;
   // up and down use the slow threshold, the rest the fast one
   localparam int SlowButtons  = 2;

   localparam logic [TickWidth-1:0]   DebounceReset = 16'd280;
   localparam logic [TickWidth-1:0]   PeriodReset   = 16'd200;
   localparam logic [ThreshWidth-1:0] SlowReset     = 8'd20;
   localparam logic [ThreshWidth-1:0] FastReset     = 8'd4;

   typedef logic [LevelWidth-1:0]  levels_type;
   typedef logic [ButtonWidth-1:0] button_type;
   typedef logic [TickWidth-1:0]   tick_type;
   typedef logic [PressWidth-1:0]  press_type;
   typedef logic [ThreshWidth-1:0] thresh_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_DEBOUNCE_TICKS = 2'd0,
      REG_PERIOD_TICKS   = 2'd1,
      REG_SLOW_THRESHOLD = 2'd2,
      REG_FAST_THRESHOLD = 2'd3
   } reg_index_type;

   typedef struct packed {
      tick_type   debounce_ticks;
      tick_type   period_ticks;
      thresh_type slow_threshold;
      thresh_type fast_threshold;
   } cfg_type;

   typedef struct packed {
      logic       event_valid;
      button_type event_button;
      logic       event_long;
   } event_type;

endpackage
`default_nettype wire

FILE: sv/button_press_classifier_unit.sv
// Top level of the debounced short/long button press classifier.
`default_nettype none
`include "button_press_classifier_unit_macros.svh"
// One request beat is one base tick carrying the four button levels, and every
// beat yields exactly one response beat (event_valid low when nothing finished).
// A beat is taken every cycle unless req_ready is held off: it is held in an input
// register, the press state is updated by a single compare and increment as it
// moves on, and the event lands in the response register, so a request passes
// the input register and then the response register. The response register and
// input register decouple the channels; only a stalled response with a full input
// register holds off req_ready. The user must write registers through the csr_ port
// only while no beat is in flight (the block does not enforce it); an update takes effect on the next tick.
module button_press_classifier_unit
   import bpc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [LevelWidth-1:0]    req_button_levels,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_event_valid,
   output logic [ButtonWidth-1:0]        rsp_event_button,
   output logic                          rsp_event_long,
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   levels_type in_levels_ff, in_levels_in;
   logic       out_valid_ff, out_valid_in;
   event_type  out_ff, out_in;
   event_type  step_result;
   logic       out_free;
   logic       advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   bpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .levels (in_levels_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_write_data[TickWidth-1:0];
            REG_PERIOD_TICKS:   cfg_in.period_ticks   = csr_write_data[TickWidth-1:0];
            REG_SLOW_THRESHOLD: cfg_in.slow_threshold = csr_write_data[ThreshWidth-1:0];
            REG_FAST_THRESHOLD: cfg_in.fast_threshold = csr_write_data[ThreshWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_levels_in = in_levels_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in  = 1'b1;
         in_levels_in = req_button_levels;
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DebounceReset;
         cfg_ff.period_ticks   <= PeriodReset;
         cfg_ff.slow_threshold <= SlowReset;
         cfg_ff.fast_threshold <= FastReset;
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_levels_ff <= in_levels_in;
      out_ff       <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_valid  = out_ff.event_valid;
   assign rsp_event_button = out_ff.event_button;
   assign rsp_event_long   = out_ff.event_long;

   // a quiet beat carries no button or long flag
   `BPC_ASSERT(a_quiet_beat_clean, clock, reset, (rsp_valid && !rsp_event_valid) |-> (rsp_event_button == '0 && !rsp_event_long), "quiet beat carries event fields")
   // long presses exist only for up and down
   `BPC_ASSERT(a_long_slow_only, clock, reset, (rsp_valid && rsp_event_long) |-> (rsp_event_valid && rsp_event_button < ButtonWidth'(SlowButtons)), "long flag on fast button")
   // a held input beat that cannot move keeps its levels
   `BPC_ASSERT(a_input_hold, clock, reset, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_levels_ff)), "input register lost a beat")
   // each moved beat fills the response register
   `BPC_ASSERT(a_advance_fills, clock, reset, advance |=> out_valid_ff, "moved beat produced no response")

endmodule
`default_nettype wire

FILE: sv/bpc_core.sv
// Press tracking state and per-tick classification step.
`default_nettype none
module bpc_core
   import bpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire levels_type levels,
   input  wire cfg_type    cfg,
   output event_type       result
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_TIMING   = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   button_type latched_ff, latched_in;
   tick_type   tick_ff, tick_in;
   press_type  press_ff, press_in;
   levels_type prev_ff, prev_in;

   always_comb begin
      tick_type   tick_inc;
      levels_type rising;
      logic       held;
      logic       slow;
      press_type  thr;
      logic       found;

      phase_in   = phase_ff;
      latched_in = latched_ff;
      tick_in    = tick_ff;
      press_in   = press_ff;
      prev_in    = prev_ff;
      result     = '0;

      tick_inc = tick_ff + 1'b1;
      rising   = levels & ~prev_ff;
      held     = levels[latched_ff];
      slow     = (latched_ff < ButtonWidth'(SlowButtons));
      thr      = {1'b0, (slow ? cfg.slow_threshold : cfg.fast_threshold)};
      found    = 1'b0;

      if (step) begin
         prev_in = levels;
         case (phase_ff)
            PH_DEBOUNCE: begin
               tick_in = tick_inc;
               if (tick_inc >= cfg.debounce_ticks) begin
                  tick_in  = '0;
                  press_in = '0;
                  if (held) begin
                     phase_in = PH_TIMING;
                  end else begin
                     phase_in   = PH_IDLE;
                     latched_in = '0;
                  end
               end
            end
            PH_TIMING: begin
               tick_in = tick_inc;
               if (tick_inc >= cfg.period_ticks) begin
                  tick_in = '0;
                  if (held && press_ff <= thr) begin
                     press_in = press_ff + 1'b1;
                  end else begin
                     result.event_valid  = 1'b1;
                     result.event_button = latched_ff;
                     result.event_long   = (press_ff > thr) && slow;
                     phase_in   = PH_IDLE;
                     latched_in = '0;
                     press_in   = '0;
                  end
               end
            end
            default: begin
               // lowest numbered rising edge wins
               phase_in = PH_IDLE;
               for (int i = 0; i < ScanButtons; i++) begin
                  if (rising[i] && !found) begin
                     found      = 1'b1;
                     latched_in = ButtonWidth'(i);
                     phase_in   = PH_DEBOUNCE;
                     tick_in    = '0;
                     press_in   = '0;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         latched_ff <= '0;
         tick_ff    <= '0;
         press_ff   <= '0;
         prev_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         latched_ff <= latched_in;
         tick_ff    <= tick_in;
         press_ff   <= press_in;
         prev_ff    <= prev_in;
      end
   end

endmodule
`default_nettype wire

FILE: tb/button_press_classifier_unit_tb.sv
// Self-checking testbench for the button press classifier with a tick-level predictor.
`default_nettype none
module button_press_classifier_unit_tb;
   import bpc_pkg::*;

   localparam int CycleLimit = 300000;

   typedef enum logic [1:0] {
      PRESS_IDLE     = 2'd0,
      PRESS_DEBOUNCE = 2'd1,
      PRESS_TIMING   = 2'd2
   } press_phase_type;

   typedef enum int {
      RSP_OPEN,
      RSP_RANDOM,
      RSP_PATTERN,
      RSP_LONG
   } stall_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   levels_type req_button_levels = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_event_valid;
   button_type rsp_event_button;
   logic rsp_event_long;
   logic csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_write_data = '0;

   button_press_classifier_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_levels(req_button_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_valid  (rsp_event_valid),
      .rsp_event_button (rsp_event_button),
      .rsp_event_long   (rsp_event_long),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state and register mirror
   cfg_type         cls_cfg;
   press_phase_type track_phase;
   button_type      track_button;
   tick_type        track_ticks;
   press_type       track_presses;
   levels_type      track_prev;

   levels_type level_beats[$];
   event_type  expected_events[$];
   event_type  want;

   int beats_queued = 0;
   int beats_taken = 0;
   int errors = 0;
   int press_events = 0;
   int long_events = 0;
   int settings_used = 0;
   int cycles = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_count = 0;
   stall_kind_type stall_mode = RSP_OPEN;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void drop_press();
      track_phase   = PRESS_IDLE;
      track_button  = '0;
      track_ticks   = '0;
      track_presses = '0;
   endfunction

   // One base tick: returns the event (all zero when nothing completes).
   function automatic event_type classify_tick(input levels_type levels);
      event_type  ev;
      levels_type rising;
      thresh_type thr;
      int         i;
      ev = '0;
      rising = levels & ~track_prev;
      case (track_phase)
         PRESS_DEBOUNCE: begin
            track_ticks = track_ticks + 1'b1;
            if (track_ticks >= cls_cfg.debounce_ticks) begin
               track_ticks = '0;
               if (levels[track_button]) begin
                  track_phase   = PRESS_TIMING;
                  track_presses = '0;
               end else begin
                  drop_press();
               end
            end
         end
         PRESS_TIMING: begin
            track_ticks = track_ticks + 1'b1;
            if (track_ticks >= cls_cfg.period_ticks) begin
               thr = (track_button < SlowButtons) ? cls_cfg.slow_threshold
                                                  : cls_cfg.fast_threshold;
               track_ticks = '0;
               if (levels[track_button] && track_presses <= thr) begin
                  track_presses = track_presses + 1'b1;
               end else begin
                  ev.event_valid  = 1'b1;
                  ev.event_button = track_button;
                  ev.event_long   = (track_presses > thr) && (track_button < SlowButtons);
                  drop_press();
               end
            end
         end
         default: begin
            track_phase = PRESS_IDLE;
            // scan high to low so the lowest rising button ends up latched
            for (i = ScanButtons - 1; i >= 0; i--) begin
               if (rising[i]) begin
                  track_button  = button_type'(i);
                  track_phase   = PRESS_DEBOUNCE;
                  track_ticks   = '0;
                  track_presses = '0;
               end
            end
         end
      endcase
      track_prev = levels;
      return ev;
   endfunction

   task automatic put_csr(input reg_index_type idx, input logic [CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   // Threshold registers get junk in the upper data bits; only the low byte counts.
   task automatic write_settings(input tick_type deb, input tick_type per,
                                 input thresh_type slow, input thresh_type fast);
      settings_used++;
      cls_cfg.debounce_ticks = deb;
      cls_cfg.period_ticks   = per;
      cls_cfg.slow_threshold = slow;
      cls_cfg.fast_threshold = fast;
      put_csr(REG_DEBOUNCE_TICKS, deb);
      put_csr(REG_PERIOD_TICKS, per);
      put_csr(REG_SLOW_THRESHOLD, {8'($urandom), slow});
      put_csr(REG_FAST_THRESHOLD, {8'($urandom), fast});
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_beat(input levels_type lv);
      level_beats.push_back(lv);
      beats_queued++;
   endtask

   task automatic wait_drained();
      while (beats_taken != beats_queued || expected_events.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Mostly clean presses (quiet tick, edge, hold, release) with random noise
   // on the other buttons; about a fifth of the picks are single pure-noise beats.
   task automatic queue_presses(input int budget);
      int made, hold, full, b, thr, eff_deb, eff_per, k, rel;
      levels_type lv;
      made = 0;
      while (made < budget) begin
         if ($urandom_range(0, 4) == 0) begin
            queue_beat(levels_type'($urandom_range(0, 15)));
            made++;
         end else begin
            b = $urandom_range(0, NumButtons - 1);
            thr = (b < SlowButtons) ? int'(cls_cfg.slow_threshold)
                                    : int'(cls_cfg.fast_threshold);
            eff_deb = (cls_cfg.debounce_ticks == 0) ? 1 : int'(cls_cfg.debounce_ticks);
            eff_per = (cls_cfg.period_ticks == 0) ? 1 : int'(cls_cfg.period_ticks);
            full = eff_deb + eff_per * (thr + 2) + 1;
            hold = $urandom_range(0, 1) ? full + $urandom_range(0, 3)
                                        : $urandom_range(1, full);
            queue_beat('0);
            made++;
            for (k = 0; k < hold && made < budget; k++) begin
               lv = levels_type'($urandom_range(0, 15));
               if (k == 0) lv = lv & ~levels_type'((1 << b) - 1);
               lv[b] = 1'b1;
               queue_beat(lv);
               made++;
            end
            rel = eff_per + $urandom_range(0, 2);
            for (k = 0; k < rel && made < budget; k++) begin
               lv = $urandom_range(0, 1) ? levels_type'($urandom_range(0, 15)) : '0;
               lv[b] = 1'b0;
               queue_beat(lv);
               made++;
            end
         end
      end
   endtask

   initial begin
      levels_type directed_ticks [25];
      int p, budget;
      cls_cfg.debounce_ticks = DebounceReset;
      cls_cfg.period_ticks   = PeriodReset;
      cls_cfg.slow_threshold = SlowReset;
      cls_cfg.fast_threshold = FastReset;
      track_prev = '0;
      drop_press();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero debounce and period behave as one; tight thresholds
      write_settings(16'd0, 16'd0, 8'd1, 8'd0);
      // all held on the first tick after reset, long up, debounce drop,
      // select and reset (long forced low), edges while busy, short presses
      directed_ticks = '{4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'h4, 4'h0,
                         4'h0, 4'hC, 4'hC, 4'hC, 4'hC, 4'h0, 4'h8, 4'h8, 4'h0,
                         4'h2, 4'h3, 4'h2, 4'h0, 4'h1, 4'h1, 4'h0};
      foreach (directed_ticks[i]) queue_beat(directed_ticks[i]);
      wait_drained();

      for (p = 0; p < 10; p++) begin
         case (p)
            0: begin
               write_settings(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
               budget = 40;
            end
            1: begin
               write_settings(16'd1, 16'd1, 8'd255, 8'd0);
               budget = 520;
            end
            2: begin
               write_settings(16'd0, 16'd0, 8'd0, 8'd255);
               budget = 150;
            end
            3: begin
               write_settings(tick_type'($urandom_range(20, 300)),
                              tick_type'($urandom_range(10, 60)),
                              thresh_type'($urandom_range(0, 2)),
                              thresh_type'($urandom_range(0, 2)));
               budget = 120;
            end
            default: begin
               write_settings(tick_type'($urandom_range(0, 8)),
                              tick_type'($urandom_range(0, 6)),
                              thresh_type'($urandom_range(0, 5)),
                              thresh_type'($urandom_range(0, 5)));
               budget = 120;
            end
         endcase
         queue_presses(budget);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Checked %0d ticks under %0d register settings;", beats_taken, settings_used);
      $display("saw %0d completed presses, %0d of them long.", press_events, long_events);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // sender: bursts of beats separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_events.push_back(classify_tick(req_button_levels));
            beats_taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (level_beats.size() > 0) begin
               req_valid <= 1'b1;
               req_button_levels <= level_beats.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure in one of four randomly chosen styles
   always @(posedge clock) begin
      stall_count++;
      if (stall_count % 128 == 0) stall_mode = stall_kind_type'($urandom_range(0, 3));
      case (stall_mode)
         RSP_OPEN:    rsp_ready <= 1'b1;
         RSP_RANDOM:  rsp_ready <= ($urandom_range(0, 3) != 0);
         RSP_PATTERN: rsp_ready <= (stall_count % 7) < 3;
         default:     rsp_ready <= ($urandom_range(0, 9) == 0) ? ~rsp_ready : rsp_ready;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: response beat with nothing expected: valid %0d button %0d long %0d",
                     $time, rsp_event_valid, rsp_event_button, rsp_event_long);
            errors++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_valid !== want.event_valid) begin
               $display("%0t: event_valid expected %0d actual %0d",
                        $time, want.event_valid, rsp_event_valid);
               errors++;
            end
            if (rsp_event_button !== want.event_button) begin
               $display("%0t: event_button expected %0d actual %0d",
                        $time, want.event_button, rsp_event_button);
               errors++;
            end
            if (rsp_event_long !== want.event_long) begin
               $display("%0t: event_long expected %0d actual %0d",
                        $time, want.event_long, rsp_event_long);
               errors++;
            end
            if (want.event_valid) begin
               press_events++;
               if (want.event_long) long_events++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("%0t: timed out with %0d beats pending and %0d responses outstanding",
                  $time, beats_queued - beats_taken, expected_events.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
`default_nettype wire
